// ----- src/sbfg_pkg.sv -----
// Package for the spectral bond factor generator.
// Types, register and mode codes, and the elaboration-time exp(-2^j) table.
// No dependencies.
`default_nettype none

package sbfg_pkg;

  localparam int KW     = 11;
  localparam int KKW    = 2 * KW;
  localparam int BW     = 52;
  localparam int SW     = BW + 2;
  localparam int XW     = 38;
  localparam int FW     = 32;
  localparam int N_STEP = 38;
  localparam int TAB_N  = 39;
  localparam int FRAC_LO = 33;

  localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_BC_MODES = 3'd3;
  localparam logic [2:0] REG_SCALE_X  = 3'd4;
  localparam logic [2:0] REG_SCALE_Y  = 3'd5;
  localparam logic [2:0] REG_SCALE_Z  = 3'd6;
  localparam logic [2:0] REG_BOND     = 3'd7;

  localparam logic [1:0] BC_PERIODIC = 2'd0;
  localparam logic [1:0] BC_REFLECT  = 2'd1;

  typedef logic [TAB_N-1:0][63:0] exp_tab_t;

  typedef struct packed {
    logic [63:0] p0;
    logic [63:0] p1;
    logic [63:0] p2;
    logic [63:0] p3;
  } pp_t;

  typedef struct packed {
    logic          sat;
    logic [XW-1:0] x;
    logic [BW-1:0] bx;
    logic [BW-1:0] by;
    logic [BW-1:0] bz;
  } carry_t;

  function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], a[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
    return p[125:62];
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] t;
    logic [63:0] s;
    logic        done;
    tab = '0;
    for (int j = 1; j <= FRAC_LO; j++) begin
      t    = ONE_Q62;
      s    = ONE_Q62;
      done = 1'b0;
      for (int n = 1; n < 64; n++) begin
        if (!done) begin
          t = div_u64(t >> j, 64'(n));
          if (t == 64'd0) begin
            done = 1'b1;
          end else if (n % 2 == 1) begin
            s = s - t;
          end else begin
            s = s + t;
          end
        end
      end
      tab[FRAC_LO - j] = s;
    end
    for (int j = 0; j + FRAC_LO < TAB_N; j++) begin
      tab[j + FRAC_LO] = mul_q62(tab[j + FRAC_LO - 1], tab[j + FRAC_LO - 1]);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- src/spectral_bond_factor_generator.sv -----
// Throughput: one transaction per cycle; a stalled output freezes every stage.
// Stages: fold, square, scale, sum, coefficient partials, exponent, then
// 38 exp steps of two stages each (partial products, then sum and round).
// Reset clears configuration to its defaults and empties the pipeline.
// Top level of the spectral bond factor generator; depends on sbfg_pkg.
`default_nettype none

module spectral_bond_factor_generator #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [9:0]  in_index_x,
  input  wire logic [9:0]  in_index_y,
  input  wire logic [9:0]  in_index_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [51:0]      out_basis_x,
  output logic [51:0]      out_basis_y,
  output logic [51:0]      out_basis_z,
  output logic [31:0]      out_full_factor,
  output logic [31:0]      out_half_factor
);

  localparam int NS  = sbfg_pkg::N_STEP;
  localparam int KW  = sbfg_pkg::KW;
  localparam int KKW = sbfg_pkg::KKW;
  localparam int BW  = sbfg_pkg::BW;
  localparam int SW  = sbfg_pkg::SW;
  localparam int XW  = sbfg_pkg::XW;

  logic [10:0] size_x_r, size_y_r, size_z_r;
  logic [5:0]  bc_modes_r;
  logic [31:0] scale_x_r, scale_y_r, scale_z_r, bond_r;

  logic adv;

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [KW-1:0]        kx_r, ky_r, kz_r;
  logic [KW-1:0]        kx_nxt, ky_nxt, kz_nxt;
  logic [KKW-1:0]       kkx_r, kky_r, kkz_r;
  logic [BW-1:0]        bx3_r, by3_r, bz3_r;
  logic [BW-1:0]        bx4_r, by4_r, bz4_r;
  logic [BW-1:0]        bx5_r, by5_r, bz5_r;
  logic [SW+1:0]        mx_nxt, my_nxt, mz_nxt;
  logic [SW-1:0]        sum_r;
  logic [63:0]          plo_r;
  logic [SW-1:0]        phi_r;
  logic [SW+31:0]       prod_nxt;
  sbfg_pkg::carry_t     car6_r;

  logic                 va_r [NS];
  logic                 vb_r [NS];
  sbfg_pkg::carry_t     cara_r [NS];
  sbfg_pkg::carry_t     carb_r [NS];
  sbfg_pkg::pp_t        ppf_r [NS];
  sbfg_pkg::pp_t        pph_r [NS];
  logic [63:0]          accf_r [NS];
  logic [63:0]          acch_r [NS];

  logic [31:0] full_nxt, half_nxt;

  function automatic logic [KW-1:0] fold_idx(input logic [9:0] idx, input logic [10:0] size,
                                             input logic [1:0] mode);
    logic [KW-1:0] sz;
    logic [KW-1:0] ix;
    if (size == 11'd0) begin
      sz = 11'd1;
    end else if (32'(size) > MAX_SIDE) begin
      sz = 11'(MAX_SIDE);
    end else begin
      sz = size;
    end
    ix = {1'b0, idx};
    unique case (mode)
      sbfg_pkg::BC_PERIODIC: begin
        if (ix > (sz >> 1)) begin
          return (sz >= ix) ? sz - ix : ix - sz;
        end
        return ix;
      end
      sbfg_pkg::BC_REFLECT: return ix;
      default: return ix + 11'd1;
    endcase
  endfunction

  function automatic sbfg_pkg::pp_t part_mul(input logic [63:0] a, input logic [63:0] t);
    sbfg_pkg::pp_t p;
    p.p0 = {32'd0, a[31:0]}  * {32'd0, t[31:0]};
    p.p1 = {32'd0, a[31:0]}  * {32'd0, t[63:32]};
    p.p2 = {32'd0, a[63:32]} * {32'd0, t[31:0]};
    p.p3 = {32'd0, a[63:32]} * {32'd0, t[63:32]};
    return p;
  endfunction

  function automatic logic [63:0] part_sum(input sbfg_pkg::pp_t p);
    logic [127:0] s;
    s = {p.p3, 64'd0} + {32'd0, p.p1, 32'd0} + {32'd0, p.p2, 32'd0} + {64'd0, p.p0}
        + (128'd1 << 61);
    return s[125:62];
  endfunction

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r   <= 11'd1;
      size_y_r   <= 11'd1;
      size_z_r   <= 11'd1;
      bc_modes_r <= '0;
      scale_x_r  <= '0;
      scale_y_r  <= '0;
      scale_z_r  <= '0;
      bond_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sbfg_pkg::REG_SIZE_X:   size_x_r   <= cfg_data[10:0];
        sbfg_pkg::REG_SIZE_Y:   size_y_r   <= cfg_data[10:0];
        sbfg_pkg::REG_SIZE_Z:   size_z_r   <= cfg_data[10:0];
        sbfg_pkg::REG_BC_MODES: bc_modes_r <= cfg_data[5:0];
        sbfg_pkg::REG_SCALE_X:  scale_x_r  <= cfg_data;
        sbfg_pkg::REG_SCALE_Y:  scale_y_r  <= cfg_data;
        sbfg_pkg::REG_SCALE_Z:  scale_z_r  <= cfg_data;
        sbfg_pkg::REG_BOND:     bond_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    kx_nxt   = fold_idx(in_index_x, size_x_r, bc_modes_r[1:0]);
    ky_nxt   = fold_idx(in_index_y, size_y_r, bc_modes_r[3:2]);
    kz_nxt   = fold_idx(in_index_z, size_z_r, bc_modes_r[5:4]);
    mx_nxt   = {34'd0, kkx_r} * {24'd0, scale_x_r};
    my_nxt   = {34'd0, kky_r} * {24'd0, scale_y_r};
    mz_nxt   = {34'd0, kkz_r} * {24'd0, scale_z_r};
    prod_nxt = {phi_r, 32'd0} + {22'd0, plo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kx_r   <= kx_nxt;
      ky_r   <= ky_nxt;
      kz_r   <= kz_nxt;
      kkx_r  <= {11'd0, kx_r} * {11'd0, kx_r};
      kky_r  <= {11'd0, ky_r} * {11'd0, ky_r};
      kkz_r  <= {11'd0, kz_r} * {11'd0, kz_r};
      bx3_r  <= mx_nxt[BW-1:0];
      by3_r  <= my_nxt[BW-1:0];
      bz3_r  <= mz_nxt[BW-1:0];
      sum_r  <= {2'd0, bx3_r} + {2'd0, by3_r} + {2'd0, bz3_r};
      bx4_r  <= bx3_r;
      by4_r  <= by3_r;
      bz4_r  <= bz3_r;
      plo_r  <= {32'd0, bond_r} * {32'd0, sum_r[31:0]};
      phi_r  <= {22'd0, bond_r} * {32'd0, sum_r[SW-1:32]};
      bx5_r  <= bx4_r;
      by5_r  <= by4_r;
      bz5_r  <= bz4_r;
      car6_r.sat <= |prod_nxt[SW+31:XW];
      car6_r.x   <= prod_nxt[XW-1:0];
      car6_r.bx  <= bx5_r;
      car6_r.by  <= by5_r;
      car6_r.bz  <= bz5_r;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic             v_in;
    sbfg_pkg::carry_t c_in;
    logic [63:0]      af_in, ah_in, tf, th;

    if (i == 0) begin : g_first
      assign v_in  = v6_r;
      assign c_in  = car6_r;
      assign af_in = sbfg_pkg::ONE_Q62;
      assign ah_in = sbfg_pkg::ONE_Q62;
    end else begin : g_next
      assign v_in  = vb_r[i-1];
      assign c_in  = carb_r[i-1];
      assign af_in = accf_r[i-1];
      assign ah_in = acch_r[i-1];
    end

    assign tf = c_in.x[i] ? sbfg_pkg::EXP_TAB[i+1] : sbfg_pkg::ONE_Q62;
    assign th = c_in.x[i] ? sbfg_pkg::EXP_TAB[i]   : sbfg_pkg::ONE_Q62;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[i] <= 1'b0;
        vb_r[i] <= 1'b0;
      end else if (adv) begin
        va_r[i] <= v_in;
        vb_r[i] <= va_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cara_r[i] <= c_in;
        ppf_r[i]  <= part_mul(af_in, tf);
        pph_r[i]  <= part_mul(ah_in, th);
        carb_r[i] <= cara_r[i];
        accf_r[i] <= part_sum(ppf_r[i]);
        acch_r[i] <= part_sum(pph_r[i]);
      end
    end
  end

  always_comb begin
    logic [63:0] rf, rh;
    rf = accf_r[NS-1] + (64'd1 << 30);
    rh = acch_r[NS-1] + (64'd1 << 30);
    full_nxt = carb_r[NS-1].sat ? 32'd0 : rf[62:31];
    half_nxt = carb_r[NS-1].sat ? 32'd0 : rh[62:31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vb_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_basis_x     <= carb_r[NS-1].bx;
      out_basis_y     <= carb_r[NS-1].by;
      out_basis_z     <= carb_r[NS-1].bz;
      out_full_factor <= full_nxt;
      out_half_factor <= half_nxt;
    end
  end

  a_sat_flush: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vb_r[NS-1] && carb_r[NS-1].sat |=>
      out_full_factor == 32'd0 && out_half_factor == 32'd0)
    else $error("saturated exponent did not flush factors");

  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vb_r[NS-1] && !carb_r[NS-1].sat && carb_r[NS-1].x == '0 |=>
      out_full_factor == 32'h8000_0000 && out_half_factor == 32'h8000_0000)
    else $error("zero exponent did not give unity factors");

endmodule

`default_nettype wire

// ----- verif/spectral_bond_factor_generator_test.sv -----
// Testbench for spectral_bond_factor_generator: random and directed grid points
// checked against a local predictor of folding, basis values and bond factors.
// Depends on sbfg_pkg and the block's RTL.
`timescale 1ns / 1ps

module spectral_bond_factor_generator_test;

  typedef struct {
    bit [9:0] x;
    bit [9:0] y;
    bit [9:0] z;
  } point_t;

  typedef struct {
    bit [51:0] bx;
    bit [51:0] by;
    bit [51:0] bz;
    bit [31:0] full;
    bit [31:0] half;
  } factors_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [9:0]  in_index_x;
  logic [9:0]  in_index_y;
  logic [9:0]  in_index_z;
  logic        out_valid;
  logic        out_stall;
  logic [51:0] out_basis_x;
  logic [51:0] out_basis_y;
  logic [51:0] out_basis_z;
  logic [31:0] out_full_factor;
  logic [31:0] out_half_factor;

  spectral_bond_factor_generator uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_index_x(in_index_x), .in_index_y(in_index_y), .in_index_z(in_index_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_basis_x(out_basis_x), .out_basis_y(out_basis_y), .out_basis_z(out_basis_z),
    .out_full_factor(out_full_factor), .out_half_factor(out_half_factor)
  );

  bit [10:0] sz_x, sz_y, sz_z;
  bit [5:0]  modes;
  bit [31:0] scl_x, scl_y, scl_z;
  bit [31:0] bond_c;
  bit [63:0] decay_tab [0:38];

  point_t   point_q[$];
  factors_t factor_q[$];
  bit       idle_en;
  bit       choke_req;
  bit       took;
  int       in_gap, out_gap, choke_left;
  int       errors, n_in, n_out, quiet;

  function automatic bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << 61);
    return p[125:62];
  endfunction

  function automatic void make_decay_tab();
    bit [63:0] t, s;
    for (int sh = 1; sh <= 33; sh++) begin
      t = 64'd1 << 62;
      s = t;
      for (int n = 1; n < 64; n++) begin
        t = (t >> sh) / n;
        if (t == 0) break;
        if (n % 2 == 1) s = s - t;
        else s = s + t;
      end
      decay_tab[33 - sh] = s;
    end
    for (int j = 33; j < 39; j++) decay_tab[j] = q62_mul(decay_tab[j-1], decay_tab[j-1]);
  endfunction

  function automatic bit [63:0] decay(bit [63:0] v, int frac);
    bit [63:0] acc;
    int k;
    acc = 64'd1 << 62;
    for (int i = 0; i < 38; i++) begin
      k = i - frac + 33;
      if (v[i] && k >= 0 && k < 39) acc = q62_mul(acc, decay_tab[k]);
    end
    return (acc + (64'd1 << 30)) >> 31;
  endfunction

  function automatic bit [63:0] fold_index(bit [9:0] idx, bit [10:0] size, bit [1:0] mode);
    bit [63:0] s, i;
    s = (size == 0) ? 1 : (size > 1024) ? 1024 : size;
    i = idx;
    if (mode == sbfg_pkg::BC_PERIODIC) begin
      if (i > s / 2) return (s >= i) ? s - i : i - s;
      return i;
    end
    if (mode == sbfg_pkg::BC_REFLECT) return i;
    return i + 1;
  endfunction

  function automatic factors_t predict_factors(point_t p);
    factors_t r;
    bit [63:0] kx, ky, kz, sum, lo, ehi, x;
    kx = fold_index(p.x, sz_x, modes[1:0]);
    ky = fold_index(p.y, sz_y, modes[3:2]);
    kz = fold_index(p.z, sz_z, modes[5:4]);
    r.bx = kx * kx * scl_x;
    r.by = ky * ky * scl_y;
    r.bz = kz * kz * scl_z;
    sum = {12'd0, r.bx} + r.by + r.bz;
    lo = bond_c * sum[31:0];
    ehi = bond_c * (sum >> 32) + (lo >> 32);
    r.full = 0;
    r.half = 0;
    if (ehi < 64) begin
      x = (ehi << 32) | lo[31:0];
      r.full = decay(x, 32);
      r.half = decay(x, 33);
    end
    return r;
  endfunction

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (point_q.size() > 0) begin
        point_t p;
        p = point_q.pop_front();
        in_index_x <= p.x;
        in_index_y <= p.y;
        in_index_z <= p.z;
        in_valid <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall: random bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (choke_req && choke_left == 0) begin
      choke_left = 400;
      choke_req = 0;
    end
    if (choke_left > 0) begin
      choke_left = choke_left - 1;
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_en && $urandom_range(0, 9) == 0) out_gap = $urandom_range(1, 8);
    end
  end

  // monitor
  always @(posedge clk) begin
    took = in_valid && !in_stall;
    if (rst_n && took) begin
      point_t p;
      p.x = in_index_x;
      p.y = in_index_y;
      p.z = in_index_z;
      factor_q.push_back(predict_factors(p));
      n_in++;
    end
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (factor_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected", $time);
      end else begin
        factors_t e;
        e = factor_q.pop_front();
        if (out_basis_x !== e.bx) begin
          errors++;
          $display("%0t: basis_x exp %h got %h", $time, e.bx, out_basis_x);
        end
        if (out_basis_y !== e.by) begin
          errors++;
          $display("%0t: basis_y exp %h got %h", $time, e.by, out_basis_y);
        end
        if (out_basis_z !== e.bz) begin
          errors++;
          $display("%0t: basis_z exp %h got %h", $time, e.bz, out_basis_z);
        end
        if (out_full_factor !== e.full) begin
          errors++;
          $display("%0t: full_factor exp %h got %h", $time, e.full, out_full_factor);
        end
        if (out_half_factor !== e.half) begin
          errors++;
          $display("%0t: half_factor exp %h got %h", $time, e.half, out_half_factor);
        end
      end
    end
    if (took || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= 20000) begin
      $display("spectral_bond_factor_generator verification failed");
      $finish;
    end
  end

  task automatic write_reg(bit [2:0] idx, bit [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      sbfg_pkg::REG_SIZE_X:   sz_x = val[10:0];
      sbfg_pkg::REG_SIZE_Y:   sz_y = val[10:0];
      sbfg_pkg::REG_SIZE_Z:   sz_z = val[10:0];
      sbfg_pkg::REG_BC_MODES: modes = val[5:0];
      sbfg_pkg::REG_SCALE_X:  scl_x = val;
      sbfg_pkg::REG_SCALE_Y:  scl_y = val;
      sbfg_pkg::REG_SCALE_Z:  scl_z = val;
      sbfg_pkg::REG_BOND:     bond_c = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic setup(bit [10:0] x, bit [10:0] y, bit [10:0] z, bit [5:0] m,
                       bit [31:0] sx, bit [31:0] sy, bit [31:0] sz, bit [31:0] c);
    write_reg(sbfg_pkg::REG_SIZE_X, {21'd0, x});
    write_reg(sbfg_pkg::REG_SIZE_Y, {21'd0, y});
    write_reg(sbfg_pkg::REG_SIZE_Z, {21'd0, z});
    write_reg(sbfg_pkg::REG_BC_MODES, {26'd0, m});
    write_reg(sbfg_pkg::REG_SCALE_X, sx);
    write_reg(sbfg_pkg::REG_SCALE_Y, sy);
    write_reg(sbfg_pkg::REG_SCALE_Z, sz);
    write_reg(sbfg_pkg::REG_BOND, c);
  endtask

  task automatic add_point(bit [9:0] x, bit [9:0] y, bit [9:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    point_q.push_back(p);
  endtask

  task automatic drain();
    while (point_q.size() > 0 || in_valid || factor_q.size() > 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  function automatic bit [9:0] pick_index(bit [10:0] size);
    int s;
    s = (size == 0) ? 1 : (size > 1024) ? 1024 : size;
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    return 10'($urandom_range(0, s - 1));
  endfunction

  function automatic bit [10:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 11'd0;
      1: return 11'd1024;
      2: return 11'd2047;
      3: return 11'($urandom);
      default: return 11'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic bit [31:0] pick_word(bit mild);
    if (mild) return $urandom_range(0, 1 << 9);
    return $urandom >> $urandom_range(0, 31);
  endfunction

  initial begin
    bit mild;
    make_decay_tab();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sbfg_pkg::REG_SIZE_X;
    cfg_data = '0;
    in_valid = 1'b0;
    in_index_x = '0;
    in_index_y = '0;
    in_index_z = '0;
    out_stall = 1'b0;
    sz_x = 1; sz_y = 1; sz_z = 1;
    modes = 0;
    scl_x = 0; scl_y = 0; scl_z = 0;
    bond_c = 0;
    idle_en = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset defaults: zero exponent everywhere
    add_point(0, 0, 0);
    add_point(1023, 1023, 1023);
    add_point(1, 512, 7);
    drain();

    // one periodic, one reflecting axis and one in mode code 2; exponents from small to saturated
    setup(8, 5, 1024, 6'b10_01_00, 32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0000_0400);
    add_point(0, 0, 0);
    add_point(4, 2, 1023);
    add_point(5, 3, 512);
    add_point(7, 4, 1);
    add_point(1023, 1023, 0);
    add_point(8, 5, 300);
    drain();
    // mode code 3, oversized and zero sizes, saturated exponent
    setup(2047, 0, 3, 6'b11_11_11, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF);
    add_point(0, 0, 0);
    add_point(1023, 1023, 1023);
    add_point(512, 1, 2);
    drain();
    // exponents well below and well above saturation, then zero coefficient
    setup(1024, 1024, 1024, 6'b00_00_00, 32'h0000_0001, 32'h0, 32'h0, 32'h0040_0000);
    add_point(0, 0, 0);
    add_point(1, 0, 0);
    add_point(2, 0, 0);
    add_point(512, 0, 0);
    add_point(513, 1023, 1023);
    drain();
    write_reg(sbfg_pkg::REG_BOND, 32'd0);
    add_point(512, 1023, 100);
    add_point(1023, 0, 0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      mild = (ph % 3 != 2);
      setup(pick_size(), pick_size(), pick_size(), 6'($urandom), pick_word(mild),
            pick_word(mild), pick_word(mild), pick_word(mild));
      if (ph == 4) choke_req = 1;
      if (ph == 11) idle_en = 0;
      repeat (155) add_point(pick_index(sz_x), pick_index(sz_y), pick_index(sz_z));
      drain();
    end

    $display("Covered %0d grid points over 17 register settings (all boundary modes,", n_in);
    $display("size clamping, saturated and zero exponents); %0d results checked.", n_out);
    if (errors == 0) begin
      $display("spectral_bond_factor_generator verification clean");
    end else begin
      $display("spectral_bond_factor_generator verification failed");
    end
    $finish;
  end

endmodule
